/* hw/rtl/dalt_pkg.sv */
package dalt_pkg;

   localparam int SAMPLE_BITS     = 12;
   localparam int SAMPLES_DEFAULT = 5;
   localparam int ANGLE_BITS      = 8;
   localparam int LEVEL_BITS      = 12;
   localparam int TOL_BITS        = 13;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 13;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_LIGHT_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOLERANCE_BRIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOLERANCE_DIM    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VERT_UPPER       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_VERT_LOWER       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HORIZ_UPPER      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HORIZ_LOWER      = 3'd6;

   // reset values
   localparam logic [LEVEL_BITS-1:0] LIGHT_THRESHOLD_RST  = 12'd1000;
   localparam logic [TOL_BITS-1:0]   TOLERANCE_BRIGHT_RST = 13'd50;
   localparam logic [TOL_BITS-1:0]   TOLERANCE_DIM_RST    = 13'd200;
   localparam logic [ANGLE_BITS-1:0] VERT_UPPER_RST       = 8'd140;
   localparam logic [ANGLE_BITS-1:0] VERT_LOWER_RST       = 8'd1;
   localparam logic [ANGLE_BITS-1:0] HORIZ_UPPER_RST      = 8'd175;
   localparam logic [ANGLE_BITS-1:0] HORIZ_LOWER_RST      = 8'd5;
   localparam logic [ANGLE_BITS-1:0] VERT_POS_RST         = 8'd45;
   localparam logic [ANGLE_BITS-1:0] HORIZ_POS_RST        = 8'd180;

   // sensor lanes
   localparam int LANE_TL = 0;
   localparam int LANE_TR = 1;
   localparam int LANE_BL = 2;
   localparam int LANE_BR = 3;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_top_left;
      logic [SAMPLE_BITS-1:0] sample_top_right;
      logic [SAMPLE_BITS-1:0] sample_bottom_left;
      logic [SAMPLE_BITS-1:0] sample_bottom_right;
   } req_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] vertical_angle;
      logic [ANGLE_BITS-1:0] horizontal_angle;
      logic                  vertical_moved;
      logic                  horizontal_moved;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] light_threshold;
      logic [TOL_BITS-1:0]   tolerance_bright;
      logic [TOL_BITS-1:0]   tolerance_dim;
      logic [ANGLE_BITS-1:0] vertical_upper_limit;
      logic [ANGLE_BITS-1:0] vertical_lower_limit;
      logic [ANGLE_BITS-1:0] horizontal_upper_limit;
      logic [ANGLE_BITS-1:0] horizontal_lower_limit;
   } cfg_type;

   typedef logic [3:0][SAMPLE_BITS-1:0] avg_type;

   // axis errors as sign and magnitude
   typedef struct packed {
      logic                 v_neg;
      logic [SAMPLE_BITS-1:0] v_mag;
      logic                 h_neg;
      logic [SAMPLE_BITS:0] h_mag;
      logic                 bright;
   } err_type;

endpackage

/* hw/rtl/dalt_accum.sv */
module dalt_accum #(
   parameter int SAMPLES = dalt_pkg::SAMPLES_DEFAULT,
   localparam int SUM_BITS = dalt_pkg::SAMPLE_BITS + $clog2(SAMPLES)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  dalt_pkg::req_type            req_data,
   output logic                         tot_valid,
   input  logic                         tot_ready,
   output logic [3:0][SUM_BITS-1:0]     tot_sums
);

   localparam int CNT_BITS = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam logic [CNT_BITS-1:0] LAST_ROUND = CNT_BITS'(SAMPLES - 1);

   logic [3:0][dalt_pkg::SAMPLE_BITS-1:0] smp;
   logic [3:0][SUM_BITS-1:0] sums_ff;
   logic [3:0][SUM_BITS-1:0] sums_in;
   logic [3:0][SUM_BITS-1:0] tot_ff;
   logic [CNT_BITS-1:0]      round_ff;
   logic                     tot_valid_ff;
   logic                     accept;
   logic                     last;

   assign smp[dalt_pkg::LANE_TL] = req_data.sample_top_left;
   assign smp[dalt_pkg::LANE_TR] = req_data.sample_top_right;
   assign smp[dalt_pkg::LANE_BL] = req_data.sample_bottom_left;
   assign smp[dalt_pkg::LANE_BR] = req_data.sample_bottom_right;

   assign req_ready = !tot_valid_ff || tot_ready;
   assign accept    = req_valid && req_ready;
   assign last      = (round_ff == LAST_ROUND);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sums_in[i] = sums_ff[i] + SUM_BITS'(smp[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff      <= '0;
         round_ff     <= '0;
         tot_valid_ff <= 1'b0;
      end else begin
         if (accept && last) begin
            tot_valid_ff <= 1'b1;
         end else if (tot_ready) begin
            tot_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (last) begin
               sums_ff  <= '0;
               round_ff <= '0;
            end else begin
               sums_ff  <= sums_in;
               round_ff <= round_ff + CNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && last) begin
         tot_ff <= sums_in;
      end
   end

   assign tot_valid = tot_valid_ff;
   assign tot_sums  = tot_ff;

endmodule

/* hw/rtl/dalt_avg.sv */
module dalt_avg #(
   parameter int SAMPLES = dalt_pkg::SAMPLES_DEFAULT,
   localparam int SUM_BITS = dalt_pkg::SAMPLE_BITS + $clog2(SAMPLES)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tot_valid,
   output logic                     tot_ready,
   input  logic [3:0][SUM_BITS-1:0] tot_sums,
   output logic                     avg_valid,
   input  logic                     avg_ready,
   output dalt_pkg::avg_type        avg_data
);

   // floor(n / SAMPLES) as (n * ceil(2^(N+L) / SAMPLES)) >> (N+L), exact for N-bit n
   localparam int LOG_S     = $clog2(SAMPLES);
   localparam int DIV_SHIFT = SUM_BITS + LOG_S;
   localparam int PROD_BITS = 2 * SUM_BITS + 1;
   localparam longint unsigned DIV_MAGIC =
      ((64'd1 << DIV_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
   localparam logic [SUM_BITS:0] MAGIC = (SUM_BITS + 1)'(DIV_MAGIC);

   logic [3:0][PROD_BITS-1:0] prod;
   dalt_pkg::avg_type         avg_in;
   dalt_pkg::avg_type         avg_ff;
   logic                      avg_valid_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod[i]   = PROD_BITS'(tot_sums[i]) * PROD_BITS'(MAGIC);
         avg_in[i] = prod[i][DIV_SHIFT +: dalt_pkg::SAMPLE_BITS];
      end
   end

   assign tot_ready = !avg_valid_ff || avg_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff <= 1'b0;
      end else if (tot_ready) begin
         avg_valid_ff <= tot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (tot_valid && tot_ready) begin
         avg_ff <= avg_in;
      end
   end

   assign avg_valid = avg_valid_ff;
   assign avg_data  = avg_ff;

endmodule

/* hw/rtl/dalt_diff.sv */
module dalt_diff (
   input  logic              clock,
   input  logic              reset,
   input  dalt_pkg::cfg_type cfg,
   input  logic              avg_valid,
   output logic              avg_ready,
   input  dalt_pkg::avg_type avg_data,
   output logic              err_valid,
   input  logic              err_ready,
   output dalt_pkg::err_type err_data
);

   localparam int SB = dalt_pkg::SAMPLE_BITS;

   logic [SB-1:0]   lt, rt, ld, rd;
   logic [SB:0]     top_sum, bot_sum, left_sum, right_sum;
   logic [SB-1:0]   top_half, bot_half;
   logic [SB+1:0]   all_sum;
   logic [SB-1:0]   mean;
   dalt_pkg::err_type err_in;
   dalt_pkg::err_type err_ff;
   logic            err_valid_ff;

   always_comb begin
      lt = avg_data[dalt_pkg::LANE_TL];
      rt = avg_data[dalt_pkg::LANE_TR];
      ld = avg_data[dalt_pkg::LANE_BL];
      rd = avg_data[dalt_pkg::LANE_BR];

      top_sum   = {1'b0, lt} + {1'b0, rt};
      bot_sum   = {1'b0, ld} + {1'b0, rd};
      left_sum  = {1'b0, lt} + {1'b0, ld};
      right_sum = {1'b0, rt} + {1'b0, rd};
      top_half  = top_sum[SB:1];
      bot_half  = bot_sum[SB:1];

      err_in.v_neg = (top_half < bot_half);
      err_in.v_mag = err_in.v_neg ? (bot_half - top_half) : (top_half - bot_half);
      // left minus right over both rows
      err_in.h_neg = (left_sum < right_sum);
      err_in.h_mag = err_in.h_neg ? (right_sum - left_sum) : (left_sum - right_sum);

      all_sum       = {1'b0, left_sum} + {1'b0, right_sum};
      mean          = all_sum[SB+1:2];
      err_in.bright = (mean > cfg.light_threshold);
   end

   assign avg_ready = !err_valid_ff || err_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_valid_ff <= 1'b0;
      end else if (avg_ready) begin
         err_valid_ff <= avg_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (avg_valid && avg_ready) begin
         err_ff <= err_in;
      end
   end

   assign err_valid = err_valid_ff;
   assign err_data  = err_ff;

endmodule

/* hw/rtl/dalt_servo.sv */
module dalt_servo (
   input  logic              clock,
   input  logic              reset,
   input  dalt_pkg::cfg_type cfg,
   input  logic              err_valid,
   output logic              err_ready,
   input  dalt_pkg::err_type err_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dalt_pkg::rsp_type rsp_data
);

   localparam int AB = dalt_pkg::ANGLE_BITS;

   logic [dalt_pkg::TOL_BITS-1:0] tol;
   logic              v_move, h_move;
   logic [AB-1:0]     vpos_ff, vpos_in;
   logic [AB-1:0]     hpos_ff, hpos_in;
   dalt_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;
   logic              accept;

   assign err_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = err_valid && err_ready;

   always_comb begin
      tol    = err_data.bright ? cfg.tolerance_bright : cfg.tolerance_dim;
      v_move = ({1'b0, err_data.v_mag} > tol);
      h_move = (err_data.h_mag > tol);

      vpos_in = vpos_ff;
      if (v_move) begin
         if (!err_data.v_neg && (vpos_ff < cfg.vertical_upper_limit)) begin
            vpos_in = vpos_ff + AB'(1);
         end else if (err_data.v_neg && (vpos_ff > cfg.vertical_lower_limit)) begin
            vpos_in = vpos_ff - AB'(1);
         end
      end

      // right brighter (negative error) steps up
      hpos_in = hpos_ff;
      if (h_move) begin
         if (err_data.h_neg && (hpos_ff < cfg.horizontal_upper_limit)) begin
            hpos_in = hpos_ff + AB'(1);
         end else if (!err_data.h_neg && (hpos_ff > cfg.horizontal_lower_limit)) begin
            hpos_in = hpos_ff - AB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vpos_ff      <= dalt_pkg::VERT_POS_RST;
         hpos_ff      <= dalt_pkg::HORIZ_POS_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            vpos_ff      <= vpos_in;
            hpos_ff      <= hpos_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.vertical_angle   <= vpos_in;
         rsp_ff.horizontal_angle <= hpos_in;
         rsp_ff.vertical_moved   <= v_move;
         rsp_ff.horizontal_moved <= h_move;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/dual_axis_light_tracker_top.sv */
// Channel   Ports                              Direction  Moves
// req       req_valid/req_ready/req_data       in         one round of four sensor samples
// rsp       rsp_valid/rsp_ready/rsp_data       out        both angles and moved flags
// csr       csr_we/csr_index/csr_wdata         in         register write, no handshake
//
// One request per cycle while req_ready is high. A result follows only the request
// that closes a batch of SAMPLES rounds; it passes through the accumulate, divide,
// error and servo registers in turn before rsp_valid rises.
// Reset clears the sums, round count and pipeline and loads the default positions.
// Each stage holds while the stage after it is full and not ready; ready ripples
// back, so req_ready drops only while a finished batch waits behind a stalled stage.
module dual_axis_light_tracker_top #(
   parameter int SAMPLES = dalt_pkg::SAMPLES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dalt_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dalt_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [dalt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dalt_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int SUM_BITS = dalt_pkg::SAMPLE_BITS + $clog2(SAMPLES);

   dalt_pkg::cfg_type        cfg_ff;
   logic                     tot_valid, tot_ready;
   logic [3:0][SUM_BITS-1:0] tot_sums;
   logic                     avg_valid, avg_ready;
   dalt_pkg::avg_type        avg_data;
   logic                     err_valid, err_ready;
   dalt_pkg::err_type        err_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_threshold        <= dalt_pkg::LIGHT_THRESHOLD_RST;
         cfg_ff.tolerance_bright       <= dalt_pkg::TOLERANCE_BRIGHT_RST;
         cfg_ff.tolerance_dim          <= dalt_pkg::TOLERANCE_DIM_RST;
         cfg_ff.vertical_upper_limit   <= dalt_pkg::VERT_UPPER_RST;
         cfg_ff.vertical_lower_limit   <= dalt_pkg::VERT_LOWER_RST;
         cfg_ff.horizontal_upper_limit <= dalt_pkg::HORIZ_UPPER_RST;
         cfg_ff.horizontal_lower_limit <= dalt_pkg::HORIZ_LOWER_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            dalt_pkg::REG_LIGHT_THRESHOLD: begin
               cfg_ff.light_threshold <= csr_wdata[dalt_pkg::LEVEL_BITS-1:0];
            end
            dalt_pkg::REG_TOLERANCE_BRIGHT: begin
               cfg_ff.tolerance_bright <= csr_wdata[dalt_pkg::TOL_BITS-1:0];
            end
            dalt_pkg::REG_TOLERANCE_DIM: begin
               cfg_ff.tolerance_dim <= csr_wdata[dalt_pkg::TOL_BITS-1:0];
            end
            dalt_pkg::REG_VERT_UPPER: begin
               cfg_ff.vertical_upper_limit <= csr_wdata[dalt_pkg::ANGLE_BITS-1:0];
            end
            dalt_pkg::REG_VERT_LOWER: begin
               cfg_ff.vertical_lower_limit <= csr_wdata[dalt_pkg::ANGLE_BITS-1:0];
            end
            dalt_pkg::REG_HORIZ_UPPER: begin
               cfg_ff.horizontal_upper_limit <= csr_wdata[dalt_pkg::ANGLE_BITS-1:0];
            end
            dalt_pkg::REG_HORIZ_LOWER: begin
               cfg_ff.horizontal_lower_limit <= csr_wdata[dalt_pkg::ANGLE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   dalt_accum #(.SAMPLES(SAMPLES)) u_accum (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .tot_valid (tot_valid),
      .tot_ready (tot_ready),
      .tot_sums  (tot_sums)
   );

   dalt_avg #(.SAMPLES(SAMPLES)) u_avg (
      .clock     (clock),
      .reset     (reset),
      .tot_valid (tot_valid),
      .tot_ready (tot_ready),
      .tot_sums  (tot_sums),
      .avg_valid (avg_valid),
      .avg_ready (avg_ready),
      .avg_data  (avg_data)
   );

   dalt_diff u_diff (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .avg_valid (avg_valid),
      .avg_ready (avg_ready),
      .avg_data  (avg_data),
      .err_valid (err_valid),
      .err_ready (err_ready),
      .err_data  (err_data)
   );

   dalt_servo u_servo (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .err_valid (err_valid),
      .err_ready (err_ready),
      .err_data  (err_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/dalt_checker.sv */
module dalt_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dalt_pkg::rsp_type rsp_data
);

   logic [dalt_pkg::ANGLE_BITS-1:0] last_v_ff;
   logic [dalt_pkg::ANGLE_BITS-1:0] last_h_ff;
   logic                            seen_ff;
   logic                            rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   // last delivered angles
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_take) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         last_v_ff <= rsp_data.vertical_angle;
         last_h_ff <= rsp_data.horizontal_angle;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response dropped or changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_v_still: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff && !rsp_data.vertical_moved
      |-> rsp_data.vertical_angle == last_v_ff)
      else $error("vertical angle changed without a move");

   a_h_still: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff && !rsp_data.horizontal_moved
      |-> rsp_data.horizontal_angle == last_h_ff)
      else $error("horizontal angle changed without a move");

   a_v_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff
      |-> (rsp_data.vertical_angle == last_v_ff) ||
          ({1'b0, rsp_data.vertical_angle} == {1'b0, last_v_ff} + 1'b1) ||
          ({1'b0, rsp_data.vertical_angle} + 1'b1 == {1'b0, last_v_ff}))
      else $error("vertical angle stepped by more than one");

endmodule

bind dual_axis_light_tracker_top dalt_checker u_dalt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/testbench.sv */
module testbench;
   import dalt_pkg::*;

   localparam int ROUNDS       = SAMPLES_DEFAULT;
   localparam int LEVEL_MAX    = (1 << SAMPLE_BITS) - 1;
   localparam int TOL_MAX      = 8190;
   localparam int ANGLE_MAX    = 180;
   localparam int DRAIN_CYCLES = 8;
   localparam int QUIET_LIMIT  = 2000;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   typedef enum int {CFG_WIDE_OPEN, CFG_FROZEN, CFG_PINNED, CFG_RANDOM} cfg_style_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // shadow of the tracker: registers, running sums and both axis positions
   cfg_type tracker_cfg = '{LIGHT_THRESHOLD_RST, TOLERANCE_BRIGHT_RST, TOLERANCE_DIM_RST,
                            VERT_UPPER_RST, VERT_LOWER_RST, HORIZ_UPPER_RST,
                            HORIZ_LOWER_RST};
   int              lane_sums [4] = '{default: 0};
   int              rounds_in_batch = 0;
   logic [7:0]      vert_pos  = VERT_POS_RST;
   logic [7:0]      horiz_pos = HORIZ_POS_RST;
   rsp_type         expected_angles [$];

   int mismatches   = 0;
   int rounds_sent  = 0;
   int quiet_cycles = 0;
   bit req_burst    = 1'b0;
   bit rsp_burst    = 1'b0;

   always #5 clock = ~clock;

   dual_axis_light_tracker_top #(.SAMPLES(ROUNDS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic void track_round(input req_type r);
      int      avg [4];
      int      dvert;
      int      dhoriz;
      int      mean;
      int      tol;
      rsp_type res;
      lane_sums[LANE_TL] += int'(r.sample_top_left);
      lane_sums[LANE_TR] += int'(r.sample_top_right);
      lane_sums[LANE_BL] += int'(r.sample_bottom_left);
      lane_sums[LANE_BR] += int'(r.sample_bottom_right);
      rounds_in_batch++;
      if (rounds_in_batch < ROUNDS) return;
      foreach (avg[i]) avg[i] = lane_sums[i] / ROUNDS;
      lane_sums = '{default: 0};
      rounds_in_batch = 0;
      dvert  = ((avg[LANE_TL] + avg[LANE_TR]) >>> 1) - ((avg[LANE_BL] + avg[LANE_BR]) >>> 1);
      dhoriz = avg[LANE_TL] - avg[LANE_TR] + avg[LANE_BL] - avg[LANE_BR];
      mean   = (avg[LANE_TL] + avg[LANE_TR] + avg[LANE_BL] + avg[LANE_BR]) / 4;
      tol    = (mean > int'(tracker_cfg.light_threshold)) ? int'(tracker_cfg.tolerance_bright)
                                                          : int'(tracker_cfg.tolerance_dim);
      res.vertical_moved = ((dvert < 0) ? -dvert : dvert) > tol;
      if (res.vertical_moved) begin
         if (dvert > 0 && vert_pos < tracker_cfg.vertical_upper_limit) vert_pos++;
         else if (dvert < 0 && vert_pos > tracker_cfg.vertical_lower_limit) vert_pos--;
      end
      // horizontal steps up when the right side is brighter
      res.horizontal_moved = ((dhoriz < 0) ? -dhoriz : dhoriz) > tol;
      if (res.horizontal_moved) begin
         if (dhoriz < 0 && horiz_pos < tracker_cfg.horizontal_upper_limit) horiz_pos++;
         else if (dhoriz > 0 && horiz_pos > tracker_cfg.horizontal_lower_limit) horiz_pos--;
      end
      res.vertical_angle   = vert_pos;
      res.horizontal_angle = horiz_pos;
      expected_angles.push_back(res);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] noisy(input int level, input int jitter);
      int v;
      v = level + int'($urandom_range(0, 2 * jitter)) - jitter;
      if (v < 0) v = 0;
      else if (v > LEVEL_MAX) v = LEVEL_MAX;
      return v[SAMPLE_BITS-1:0];
   endfunction

   task automatic send_round(input req_type round_in);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= round_in;
      do @(posedge clock); while (!req_ready);
      track_round(round_in);
      rounds_sent++;
      if (rounds_sent % 32 == 0) req_burst = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_batch(input int tl, input int tr, input int bl, input int br,
                             input int jitter);
      req_type r;
      repeat (ROUNDS) begin
         r.sample_top_left     = noisy(tl, jitter);
         r.sample_top_right    = noisy(tr, jitter);
         r.sample_bottom_left  = noisy(bl, jitter);
         r.sample_bottom_right = noisy(br, jitter);
         send_round(r);
      end
   endtask

   task automatic send_raw_round(input bit extremes);
      logic [63:0] bits;
      req_type     r;
      bits = {$urandom, $urandom};
      r = bits[$bits(req_type)-1:0];
      if (extremes) r = {{SAMPLE_BITS{bits[0]}}, {SAMPLE_BITS{bits[1]}},
                         {SAMPLE_BITS{bits[2]}}, {SAMPLE_BITS{bits[3]}}};
      send_round(r);
   endtask

   task automatic send_random_batch(input int v_dir, input int h_dir);
      int pick;
      int mid;
      int v_off;
      int h_off;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         // a light source off to one side: lanes skewed around a common level
         mid   = $urandom_range(0, LEVEL_MAX);
         v_off = v_dir * int'($urandom_range(0, 1500));
         h_off = h_dir * int'($urandom_range(0, 1500));
         send_batch(mid + v_off + h_off, mid + v_off - h_off, mid - v_off + h_off,
                    mid - v_off - h_off, $urandom_range(0, 80));
      end else begin
         repeat (ROUNDS) send_raw_round(pick >= 88);
      end
   endtask

   task automatic reg_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_LIGHT_THRESHOLD:  tracker_cfg.light_threshold        = val[LEVEL_BITS-1:0];
         REG_TOLERANCE_BRIGHT: tracker_cfg.tolerance_bright       = val[TOL_BITS-1:0];
         REG_TOLERANCE_DIM:    tracker_cfg.tolerance_dim          = val[TOL_BITS-1:0];
         REG_VERT_UPPER:       tracker_cfg.vertical_upper_limit   = val[ANGLE_BITS-1:0];
         REG_VERT_LOWER:       tracker_cfg.vertical_lower_limit   = val[ANGLE_BITS-1:0];
         REG_HORIZ_UPPER:      tracker_cfg.horizontal_upper_limit = val[ANGLE_BITS-1:0];
         REG_HORIZ_LOWER:      tracker_cfg.horizontal_lower_limit = val[ANGLE_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // junk in the unused upper data bits must not reach the registers
   task automatic program_config(input cfg_type c);
      reg_write(REG_LIGHT_THRESHOLD, {1'($urandom_range(0, 1)), c.light_threshold});
      reg_write(REG_TOLERANCE_BRIGHT, c.tolerance_bright);
      reg_write(REG_TOLERANCE_DIM, c.tolerance_dim);
      reg_write(REG_VERT_UPPER, {5'($urandom_range(0, 31)), c.vertical_upper_limit});
      reg_write(REG_VERT_LOWER, {5'($urandom_range(0, 31)), c.vertical_lower_limit});
      reg_write(REG_HORIZ_UPPER, {5'($urandom_range(0, 31)), c.horizontal_upper_limit});
      reg_write(REG_HORIZ_LOWER, {5'($urandom_range(0, 31)), c.horizontal_lower_limit});
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_idle_defaults();
      send_batch(0, 0, 0, 0, 0);
   endtask

   // full-scale skews; horizontal starts above its upper limit and may only step back
   task automatic test_full_scale();
      send_batch(LEVEL_MAX, 0, 0, 0, 0);
      send_batch(0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 0);
   endtask

   // mean sits on the threshold (dim band); difference at the band edge, then one past
   task automatic test_dead_band();
      send_batch(1100, 1100, 900, 900, 0);
      send_batch(1101, 1101, 900, 900, 0);
   endtask

   task automatic test_limit_hold();
      wait_idle();
      reg_write(REG_VERT_UPPER, {5'b10110, vert_pos});
      reg_write(REG_VERT_LOWER, {5'b01001, 8'd0});
      reg_write(REG_UNUSED, '1);
      send_batch(LEVEL_MAX, LEVEL_MAX, 0, 0, 0);
   endtask

   task automatic random_phase(input cfg_style_type style, input int batches);
      cfg_type c;
      int      v_dir;
      int      h_dir;
      wait_idle();
      c.light_threshold  = LEVEL_BITS'($urandom_range(0, LEVEL_MAX));
      c.tolerance_bright = ($urandom_range(0, 3) == 0) ? TOL_BITS'($urandom_range(0, TOL_MAX))
                                                       : TOL_BITS'($urandom_range(0, 300));
      c.tolerance_dim    = ($urandom_range(0, 3) == 0) ? TOL_BITS'($urandom_range(0, TOL_MAX))
                                                       : TOL_BITS'($urandom_range(0, 800));
      c.vertical_upper_limit   = ANGLE_BITS'($urandom_range(0, ANGLE_MAX));
      c.vertical_lower_limit   = ANGLE_BITS'($urandom_range(0, ANGLE_MAX));
      c.horizontal_upper_limit = ANGLE_BITS'($urandom_range(0, ANGLE_MAX));
      c.horizontal_lower_limit = ANGLE_BITS'($urandom_range(0, ANGLE_MAX));
      case (style)
         CFG_WIDE_OPEN: begin
            c.light_threshold        = '0;
            c.tolerance_bright       = '0;
            c.tolerance_dim          = '0;
            c.vertical_upper_limit   = ANGLE_BITS'(ANGLE_MAX);
            c.vertical_lower_limit   = '0;
            c.horizontal_upper_limit = ANGLE_BITS'(ANGLE_MAX);
            c.horizontal_lower_limit = '0;
         end
         CFG_FROZEN: begin
            c.light_threshold  = LEVEL_BITS'(LEVEL_MAX);
            c.tolerance_bright = TOL_BITS'(TOL_MAX);
            c.tolerance_dim    = TOL_BITS'(TOL_MAX);
         end
         CFG_PINNED: begin
            c.vertical_upper_limit   = '0;
            c.vertical_lower_limit   = ANGLE_BITS'(ANGLE_MAX);
            c.horizontal_upper_limit = '0;
            c.horizontal_lower_limit = ANGLE_BITS'(ANGLE_MAX);
         end
         default: ;
      endcase
      program_config(c);
      // a steady drift per phase walks the positions into their limits
      v_dir = $urandom_range(0, 1) ? 1 : -1;
      h_dir = $urandom_range(0, 1) ? 1 : -1;
      repeat (batches) begin
         if ($urandom_range(0, 2) == 0)
            send_random_batch($urandom_range(0, 1) ? 1 : -1, $urandom_range(0, 1) ? 1 : -1);
         else
            send_random_batch(v_dir, h_dir);
      end
      // possibly leave a partial batch open across the next register update
      repeat ($urandom_range(0, 4)) send_raw_round(1'b0);
   endtask

   task automatic test_random_phases();
      random_phase(CFG_WIDE_OPEN, 26);
      random_phase(CFG_RANDOM, 26);
      random_phase(CFG_FROZEN, 26);
      random_phase(CFG_RANDOM, 26);
      random_phase(CFG_PINNED, 26);
      random_phase(CFG_RANDOM, 26);
      random_phase(CFG_WIDE_OPEN, 26);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_idle_defaults();
      test_full_scale();
      test_dead_band();
      test_limit_hold();
      test_random_phases();
      wait_idle();
      if (mismatches == 0 && expected_angles.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : result_check
      rsp_type want;
      int      gap;
      int      results_seen;
      results_seen = 0;
      do @(posedge clock); while (reset);
      forever begin
         gap = rsp_burst ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (expected_angles.size() == 0) begin
            $error("result with no completed batch pending");
            mismatches++;
         end else begin
            want = expected_angles.pop_front();
            if (rsp_data.vertical_angle !== want.vertical_angle) begin
               $error("vertical_angle: expected %0d, actual %0d",
                      want.vertical_angle, rsp_data.vertical_angle);
               mismatches++;
            end
            if (rsp_data.horizontal_angle !== want.horizontal_angle) begin
               $error("horizontal_angle: expected %0d, actual %0d",
                      want.horizontal_angle, rsp_data.horizontal_angle);
               mismatches++;
            end
            if (rsp_data.vertical_moved !== want.vertical_moved) begin
               $error("vertical_moved: expected %0d, actual %0d",
                      want.vertical_moved, rsp_data.vertical_moved);
               mismatches++;
            end
            if (rsp_data.horizontal_moved !== want.horizontal_moved) begin
               $error("horizontal_moved: expected %0d, actual %0d",
                      want.horizontal_moved, rsp_data.horizontal_moved);
               mismatches++;
            end
         end
         results_seen++;
         if (results_seen % 16 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
      end
   end

   // a request or a result accepted resets the hang counter
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/dalt_pkg.sv
hw/rtl/dalt_accum.sv
hw/rtl/dalt_avg.sv
hw/rtl/dalt_diff.sv
hw/rtl/dalt_servo.sv
hw/rtl/dual_axis_light_tracker_top.sv
hw/rtl/dalt_checker.sv
tb/testbench.sv
